### design/psgm_pkg.sv
`default_nettype none

package psgm_pkg;

  localparam int VOICES = 4;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam int PHASE_W = 24;
  localparam int WAVE_W  = 17;
  localparam int PROD_W  = 22;
  localparam int ACC_W   = PROD_W + $clog2(VOICES);
  localparam int MAG_W   = ACC_W - 1;
  localparam int GAIN_W  = 10;
  localparam int GPROD_W = MAG_W + GAIN_W;
  localparam int SCALE_SHIFT = 16;
  localparam int SH_W    = GPROD_W - SCALE_SHIFT;

  localparam logic [15:0]     PHASE_SCALE_RST = 16'd36281;
  localparam logic [GAIN_W-1:0] OUT_GAIN_RST = 10'd221;
  localparam logic [31:0]     NOISE_SEED = 32'h1234ACE1;
  localparam logic [31:0]     NOISE_STEP = 32'h9E3779B1;

  localparam logic signed [WAVE_W-1:0] WAVE_HI = 17'sd32768;
  localparam logic signed [WAVE_W-1:0] WAVE_LO = -17'sd32768;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_TICK     = 2'd1,
    OP_NOTE_ON  = 2'd2,
    OP_NOTE_OFF = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    WAVE_PULSE = 2'd0,
    WAVE_SAW   = 2'd1,
    WAVE_TRI   = 2'd2,
    WAVE_NOISE = 2'd3
  } wave_t;

  typedef enum logic [0:0] {
    CFG_PHASE_SCALE = 1'd0,
    CFG_OUT_GAIN    = 1'd1
  } cfg_t;

  typedef struct packed {
    logic [7:0]         volpan;
    logic [7:0]         decay;
    wave_t              wave;
    logic [5:0]         pulse;
    logic [15:0]        freq;
    logic [PHASE_W-1:0] phase;
    logic [31:0]        noise;
    logic               nbit;
  } voice_t;

  function automatic voice_t voice_reset(input logic [VIDX_W-1:0] idx);
    voice_t r;
    r = '0;
    r.noise = NOISE_SEED ^ (32'(idx) * NOISE_STEP);
    return r;
  endfunction

endpackage

`default_nettype wire

### design/four_voice_psg_mixer.sv
`default_nettype none

// Four-voice sound generator with a stereo mix. All per-voice state sits in
// one small synchronous memory; an entry that was never written reads as its
// reset value, so no clearing pass follows reset. A sample or a tick walks
// the voices through a single read port, one voice per cycle, into a short
// read-modify-write pipeline; a note-on or note-off reads only its voice. A
// sample transaction holds off new input until its result is loaded into
// the output register; a tick or note operation does so until its last
// voice has been written back. The output register lets the next transaction
// start while a result is still waiting.
module four_voice_psg_mixer
  import psgm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic [1:0]         voice,
  input  wire logic [7:0]         vol_pan,
  input  wire logic [7:0]         shape,
  input  wire logic [7:0]         decay_step,
  input  wire logic [15:0]        note_freq,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      left,
  output logic signed [15:0]      right
);

  logic [15:0]       phase_scale;
  logic [GAIN_W-1:0] out_gain;

  logic        busy;
  op_t         op_q;
  logic [7:0]  vol_pan_q;
  logic [7:0]  shape_q;
  logic [7:0]  decay_q;
  logic [15:0] freq_q;

  logic              issuing;
  logic              issue_single;
  logic [VIDX_W-1:0] issue_idx;
  logic              issue_last;

  voice_t            mem [VOICES];
  logic [VOICES-1:0] ent_ok;
  voice_t            mem_q;
  logic              vbit_q;

  logic              a_vld;
  logic              a_last;
  logic [VIDX_W-1:0] a_idx;
  voice_t            a_ent;
  logic [31:0]       inc_full;

  logic               b_vld;
  logic               b_last;
  logic [VIDX_W-1:0]  b_idx;
  voice_t             b_ent;
  logic [PHASE_W-1:0] b_inc;
  voice_t             nxt;
  logic               act;
  logic [PHASE_W:0]   phase_sum;
  logic [31:0]        noise_x;
  logic [1:0]         pan;
  logic signed [WAVE_W-1:0] wave_val;

  logic                     c_vld;
  logic                     c_last;
  logic signed [WAVE_W-1:0] c_wave;
  logic [5:0]               c_vol;
  logic                     c_l;
  logic                     c_r;
  logic signed [23:0]       mul_c;

  logic                     d_vld;
  logic                     d_last;
  logic signed [PROD_W-1:0] d_prod;
  logic                     d_l;
  logic                     d_r;

  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;

  logic               e_vld;
  logic [ACC_W-1:0]   neg_acc_l;
  logic [ACC_W-1:0]   neg_acc_r;
  logic [MAG_W-1:0]   mag_l;
  logic [MAG_W-1:0]   mag_r;

  logic               m_vld;
  logic               m_neg_l;
  logic               m_neg_r;
  logic [GPROD_W-1:0] m_l;
  logic [GPROD_W-1:0] m_r;

  logic accept;
  logic note_op;
  logic in_range;
  logic out_load;

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic signed [WAVE_W-1:0] wave_of(input voice_t e);
    logic signed [WAVE_W:0] t;
    logic signed [WAVE_W-1:0] w;
    t = '0;
    unique case (e.wave)
      WAVE_PULSE: w = (e.phase < {e.pulse, 18'd0}) ? WAVE_HI : WAVE_LO;
      WAVE_SAW: begin
        t = $signed({2'b00, e.phase[23:8]}) - 18'sd32768;
        w = t[WAVE_W-1:0];
      end
      WAVE_TRI: begin
        if (!e.phase[23]) begin
          t = $signed({2'b00, e.phase[22:7]}) - 18'sd32768;
        end else begin
          t = 18'sd98304 - $signed({1'b0, e.phase[23:7]});
        end
        w = t[WAVE_W-1:0];
      end
      WAVE_NOISE: w = e.nbit ? WAVE_HI : WAVE_LO;
      default: w = WAVE_LO;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] saturate(input logic neg, input logic [SH_W-1:0] mag);
    logic [15:0] r;
    if (neg) begin
      if (mag >= 32768) r = 16'h8000;
      else r = 16'd0 - 16'(mag);
    end else begin
      if (mag >= 32767) r = 16'h7FFF;
      else r = 16'(mag);
    end
    return r;
  endfunction

  assign note_op  = (opcode == OP_NOTE_ON) || (opcode == OP_NOTE_OFF);
  assign in_range = (32'(voice) < VOICES);
  assign in_ready = !busy;
  assign accept   = in_valid && !busy;
  assign issue_last = issue_single || (issue_idx == VIDX_W'(VOICES - 1));
  assign out_load = m_vld && (!out_valid || out_ready);

  assign a_ent    = vbit_q ? mem_q : voice_reset(a_idx);
  assign inc_full = 32'(a_ent.freq) * 32'(phase_scale);

  assign phase_sum = {1'b0, b_ent.phase} + {1'b0, b_inc};
  assign noise_x   = xorshift(b_ent.noise);

  always_comb begin
    nxt = b_ent;
    act = 1'b0;
    unique case (op_q)
      OP_SAMPLE: begin
        act = (b_ent.volpan[5:0] != 6'd0) && (b_ent.freq != 16'd0);
        if (act) begin
          nxt.phase = phase_sum[PHASE_W-1:0];
          if (phase_sum[PHASE_W] && (b_ent.wave == WAVE_NOISE)) begin
            nxt.noise = noise_x;
            nxt.nbit  = noise_x[0];
          end
        end
      end
      OP_TICK: begin
        if (b_ent.decay != 8'd0) begin
          if (b_ent.decay >= {2'b00, b_ent.volpan[5:0]}) begin
            nxt.volpan[5:0] = 6'd0;
            nxt.decay       = 8'd0;
          end else begin
            nxt.volpan[5:0] = b_ent.volpan[5:0] - b_ent.decay[5:0];
          end
        end
      end
      OP_NOTE_ON: begin
        nxt.volpan = vol_pan_q;
        nxt.decay  = decay_q;
        nxt.wave   = wave_t'(shape_q[1:0]);
        nxt.pulse  = shape_q[7:2];
        nxt.freq   = freq_q;
      end
      OP_NOTE_OFF: begin
        nxt.volpan = 8'd0;
        nxt.decay  = 8'd0;
      end
      default: nxt = b_ent;
    endcase
  end

  assign wave_val = wave_of(nxt);
  assign pan      = b_ent.volpan[7:6];
  assign mul_c    = c_wave * $signed({1'b0, c_vol});

  assign neg_acc_l = ACC_W'(0) - acc_l;
  assign neg_acc_r = ACC_W'(0) - acc_r;
  assign mag_l = acc_l[ACC_W-1] ? neg_acc_l[MAG_W-1:0] : acc_l[MAG_W-1:0];
  assign mag_r = acc_r[ACC_W-1] ? neg_acc_r[MAG_W-1:0] : acc_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_scale <= PHASE_SCALE_RST;
      out_gain    <= OUT_GAIN_RST;
      busy        <= 1'b0;
      issuing     <= 1'b0;
      ent_ok      <= '0;
      a_vld       <= 1'b0;
      b_vld       <= 1'b0;
      c_vld       <= 1'b0;
      d_vld       <= 1'b0;
      e_vld       <= 1'b0;
      m_vld       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_t'(cfg_index))
          CFG_PHASE_SCALE: phase_scale <= cfg_data;
          CFG_OUT_GAIN:    out_gain <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (accept && (!note_op || in_range)) begin
        busy    <= 1'b1;
        issuing <= 1'b1;
      end else if (issuing && issue_last) begin
        issuing <= 1'b0;
      end

      a_vld <= issuing;
      b_vld <= a_vld;
      c_vld <= b_vld && (op_q == OP_SAMPLE);
      d_vld <= c_vld;
      e_vld <= d_vld && d_last;

      if (b_vld) begin
        ent_ok[b_idx] <= 1'b1;
      end

      if (b_vld && b_last && (op_q != OP_SAMPLE)) begin
        busy <= 1'b0;
      end

      if (e_vld) begin
        m_vld <= 1'b1;
      end else if (out_load) begin
        m_vld <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
        busy      <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q         <= op_t'(opcode);
      vol_pan_q    <= vol_pan;
      shape_q      <= shape;
      decay_q      <= decay_step;
      freq_q       <= note_freq;
      issue_single <= note_op;
      issue_idx    <= note_op ? VIDX_W'(voice) : '0;
      acc_l        <= '0;
      acc_r        <= '0;
    end else begin
      if (issuing && !issue_last) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (d_vld) begin
        if (d_l) begin
          acc_l <= acc_l + ACC_W'(d_prod);
        end
        if (d_r) begin
          acc_r <= acc_r + ACC_W'(d_prod);
        end
      end
    end

    if (issuing) begin
      mem_q  <= mem[issue_idx];
      vbit_q <= ent_ok[issue_idx];
      a_idx  <= issue_idx;
      a_last <= issue_last;
    end

    b_ent  <= a_ent;
    b_inc  <= inc_full[31:8];
    b_idx  <= a_idx;
    b_last <= a_last;

    c_wave <= wave_val;
    c_vol  <= nxt.volpan[5:0];
    c_l    <= act && (pan[0] || (pan == 2'b00));
    c_r    <= act && (pan[1] || (pan == 2'b00));
    c_last <= b_last;

    d_prod <= mul_c[PROD_W-1:0];
    d_l    <= c_l;
    d_r    <= c_r;
    d_last <= c_last;

    if (e_vld) begin
      m_neg_l <= acc_l[ACC_W-1];
      m_neg_r <= acc_r[ACC_W-1];
      m_l     <= GPROD_W'(mag_l) * GPROD_W'(out_gain);
      m_r     <= GPROD_W'(mag_r) * GPROD_W'(out_gain);
    end

    if (out_load) begin
      left  <= saturate(m_neg_l, m_l[GPROD_W-1:SCALE_SHIFT]);
      right <= saturate(m_neg_r, m_r[GPROD_W-1:SCALE_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld) begin
      mem[b_idx] <= nxt;
    end
  end

endmodule

`default_nettype wire
